@@ hdl/iaot_pkg.sv @@
// ----------------------------------------------------------------------------
// iaot_pkg: shared definitions for the inode attribute offset table
// Request, status and register codes, dictionary geometry, stream payload
// widths and the free space calculation.
// ----------------------------------------------------------------------------
package iaot_pkg;

	// dictionary geometry
	localparam int ENTRIES      = 64;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int HEADER_BYTES = 16;

	// stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_USER_W = 2;

	// configuration port
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_RESIZE = 2'd1,
		REQ_PURGE  = 2'd2,
		REQ_FIND   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_RANGE   = 2'd2,
		ST_NOSPACE = 2'd3
	} status_t;

	typedef enum logic {
		CFG_BLOCK_SIZE = 1'b0,
		CFG_BASE_INUM  = 1'b1
	} cfg_idx_t;

	// free bytes: block minus header, data and two bytes per entry, floored at zero
	function automatic logic [15:0] free_calc(input logic [15:0] blk,
			input logic [CNT_W-1:0] cnt, input logic [15:0] tail);
		logic signed [19:0] f;
		logic [15:0] used;
		used = (cnt == '0) ? 16'd0 : tail;
		f = signed'({4'b0, blk}) - 20'(HEADER_BYTES) - signed'({4'b0, used})
			- signed'(20'({cnt, 1'b0}));
		return (f < 0) ? 16'd0 : f[15:0];
	endfunction

endpackage

@@ hdl/inode_attribute_offset_table_core.sv @@
// ----------------------------------------------------------------------------
// inode_attribute_offset_table_core: offset dictionary of one inode-table block
// Serves lookup, resize, purge and find-empty requests on a dictionary of
// cumulative end offsets held in a single-port-read, single-port-write RAM.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_ stream (request kind in s_tuser), one result per
//   request leaves on the m_ stream (status in m_tuser). block_size and
//   base_inum are to be written on the cfg_ channel while no request is in
//   flight; the core itself does not enforce this. One request is worked at
//   a time: s_tready is high only while the sequencer is idle. Every request
//   reads tail, previous and own end offset from the RAM, is evaluated and
//   then loads the result.
//   Resize walks entries from the target to the count (or fills new entries),
//   one per cycle; purge walks the same way and then scans trailing entries
//   downward, one per cycle; find-empty scans upward one entry per cycle.
//   Worst case is a purge at entry 0 of a full table. The registered RAM
//   read sets the per-entry pace.
//   The result register parts the two sides: a new request is taken while a
//   result waits, and the next result waits in the sequencer until m_tready.
//   Reset empties the dictionary (count 0), sets block_size 4096, base 0.
//   No clearing pass is needed: entries at or above the count are never used.
// ----------------------------------------------------------------------------
module inode_attribute_offset_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [iaot_pkg::IN_DATA_W-1:0]   s_tdata,  // inum[63:0], new_size[79:64]
	input  logic [iaot_pkg::IN_USER_W-1:0]   s_tuser,  // req_type[1:0]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [iaot_pkg::OUT_DATA_W-1:0]  m_tdata,  // attr_offset[15:0], attr_size[31:16],
	                                                   // found_inum[95:32], free_bytes[111:96]
	output logic [iaot_pkg::OUT_USER_W-1:0]  m_tuser,  // status[1:0]
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [iaot_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import iaot_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_EVAL = 8'b0000_0100,
		S_FILL = 8'b0000_1000,
		S_WALK = 8'b0001_0000,
		S_TRIM = 8'b0010_0000,
		S_SCAN = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [1:0]         step_q;

	// configuration
	logic [15:0]        block_size_q;
	logic [63:0]        base_inum_q;

	// request
	req_t               req_q;
	logic [63:0]        inum_q;
	logic [15:0]        new_size_q;
	logic               in_range_q;
	logic [IDX_W-1:0]   at_q;

	// dictionary state and working values
	logic [CNT_W-1:0]   count_q;
	logic [15:0]        tail_q;
	logic [15:0]        prev_q;
	logic [15:0]        cur_q;
	logic [15:0]        free_q;
	logic [15:0]        delta_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               trim_go_q;
	logic [15:0]        scan_prev_q;
	logic [CNT_W-1:0]   hit_idx_q;
	logic               fnd_en_q;
	logic               fnd_scan_q;

	// result fields
	status_t            status_q;
	logic [15:0]        offset_q;
	logic [15:0]        size_q;

	// output register
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	// ram
	logic [15:0]        mem [ENTRIES];
	logic [15:0]        rdata_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               rd_issue;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [15:0]        wr_data;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;

	// combinational helpers
	logic [64:0]        diff_w;
	logic               range_w;
	logic               lt_w;
	logic [15:0]        size_cur_w;
	logic [15:0]        size_rs_w;
	logic [15:0]        off_rs_w;
	logic signed [16:0] more_w;
	logic [CNT_W-1:0]   extend_w;
	logic signed [19:0] need_w;
	logic               refuse_w;
	logic               out_free_w;
	logic [63:0]        found_w;
	logic [15:0]        free_fin_w;
	status_t            eval_status_w;
	logic [15:0]        eval_offset_w;
	logic [15:0]        eval_size_w;
	state_t             eval_next_w;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// range check of the incoming inode number
	assign diff_w  = {1'b0, s_tdata[63:0]} - {1'b0, base_inum_q};
	assign range_w = !diff_w[64] && (diff_w[63:0] < 64'(ENTRIES));

	// evaluation of the fetched entries
	assign lt_w       = (CNT_W'(at_q) < count_q);
	assign size_cur_w = cur_q - prev_q;
	assign size_rs_w  = lt_w ? size_cur_w : 16'd0;
	assign off_rs_w   = lt_w ? prev_q : tail_q;
	assign more_w     = signed'({1'b0, new_size_q}) - signed'({1'b0, size_rs_w});
	assign extend_w   = lt_w ? '0 : (CNT_W'(at_q) - count_q + CNT_W'(1));
	assign need_w     = 20'(more_w) + signed'(20'({extend_w, 1'b0}));
	assign refuse_w   = (more_w > 0) && (need_w > signed'({4'b0, free_q}));

	// request decode: result fields and the next step
	always_comb begin
		eval_status_w = ST_OK;
		eval_offset_w = 16'd0;
		eval_size_w   = 16'd0;
		eval_next_w   = S_FIN;
		if (!in_range_q) begin
			eval_status_w = ST_RANGE;
		end else begin
			unique case (req_q)
				REQ_LOOKUP: begin
					if (lt_w) begin
						eval_offset_w = prev_q;
						eval_size_w   = size_cur_w;
						if (size_cur_w == 16'd0) begin
							eval_status_w = ST_EMPTY;
						end
					end else begin
						eval_status_w = ST_EMPTY;
					end
				end
				REQ_RESIZE: begin
					eval_offset_w = off_rs_w;
					eval_size_w   = size_rs_w;
					if (refuse_w) begin
						eval_status_w = ST_NOSPACE;
					end else begin
						eval_next_w = lt_w ? S_WALK : S_FILL;
					end
				end
				REQ_PURGE: begin
					if (!lt_w) begin
						eval_status_w = ST_EMPTY;
					end else begin
						eval_offset_w = prev_q;
						eval_size_w   = size_cur_w;
						if (size_cur_w == 16'd0) begin
							eval_status_w = ST_EMPTY;
						end else begin
							eval_next_w = S_WALK;
						end
					end
				end
				REQ_FIND: begin
					if (lt_w) begin
						eval_next_w = S_SCAN;
					end
				end
				default: ;
			endcase
		end
	end

	// result assembly
	assign out_free_w = !m_tvalid_q || m_tready;
	assign free_fin_w = free_calc(block_size_q, count_q, tail_q);
	always_comb begin
		found_w = 64'd0;
		if (fnd_en_q) begin
			found_w = fnd_scan_q ? (base_inum_q + 64'(hit_idx_q)) : inum_q;
		end
	end

	// ram read address and issue
	always_comb begin
		rd_addr  = ptr_q[IDX_W-1:0];
		rd_issue = 1'b0;
		unique case (state_q)
			S_RD: begin
				case (step_q)
					2'd0:    rd_addr = IDX_W'(count_q - CNT_W'(1));
					2'd1:    rd_addr = at_q - IDX_W'(1);
					default: rd_addr = at_q;
				endcase
			end
			S_WALK, S_SCAN: rd_issue = (ptr_q < count_q);
			S_TRIM:         rd_issue = trim_go_q;
			default: ;
		endcase
	end

	// ram write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = tail_q;
		unique case (state_q)
			S_FILL: begin
				wr_en   = 1'b1;
				wr_data = (ptr_q[IDX_W-1:0] == at_q) ? (tail_q + delta_q) : tail_q;
			end
			S_WALK: begin
				wr_en   = valid_s1;
				wr_addr = idx_s1;
				wr_data = rdata_q + delta_q;
			end
			default: ;
		endcase
	end

	// dictionary ram
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// read tracking for the walks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 16'd4096;
			base_inum_q  <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BLOCK_SIZE: block_size_q <= cfg_data[15:0];
				CFG_BASE_INUM:  base_inum_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= 2'd0;
			count_q    <= '0;
			trim_go_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result transfer frees the output register unless a new one loads
			if (m_tvalid_q && m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q      <= req_t'(s_tuser[1:0]);
						inum_q     <= s_tdata[63:0];
						new_size_q <= s_tdata[79:64];
						in_range_q <= range_w;
						at_q       <= diff_w[IDX_W-1:0];
						step_q     <= 2'd0;
						state_q    <= S_RD;
					end
				end
				// fetch tail, previous and own end offsets
				S_RD: begin
					step_q <= step_q + 2'd1;
					case (step_q)
						2'd1: tail_q <= (count_q == '0) ? 16'd0 : rdata_q;
						2'd2: prev_q <= (at_q == '0) ? 16'd0 : rdata_q;
						2'd3: begin
							cur_q   <= rdata_q;
							free_q  <= free_calc(block_size_q, count_q, tail_q);
							state_q <= S_EVAL;
						end
						default: ;
					endcase
				end
				// latch the decoded result and set up the walk
				S_EVAL: begin
					fnd_en_q    <= in_range_q && (req_q == REQ_FIND);
					fnd_scan_q  <= in_range_q && (req_q == REQ_FIND) && lt_w;
					status_q    <= eval_status_w;
					offset_q    <= eval_offset_w;
					size_q      <= eval_size_w;
					state_q     <= eval_next_w;
					delta_q     <= (req_q == REQ_PURGE) ? (16'd0 - size_cur_w) : more_w[15:0];
					ptr_q       <= lt_w ? CNT_W'(at_q) : count_q;
					scan_prev_q <= prev_q;
				end
				// append empty entries up to the target, target takes the growth
				S_FILL: begin
					if (ptr_q[IDX_W-1:0] == at_q) begin
						count_q <= CNT_W'(at_q) + CNT_W'(1);
						tail_q  <= tail_q + delta_q;
						state_q <= S_FIN;
					end else begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				// shift end offsets from the target to the count
				S_WALK: begin
					if (rd_issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end else if (!valid_s1) begin
						tail_q <= tail_q + delta_q;
						if (req_q == REQ_PURGE) begin
							trim_go_q <= (count_q >= CNT_W'(2));
							ptr_q     <= count_q - CNT_W'(2);
							state_q   <= S_TRIM;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				// drop trailing entries that equal the tail, downward
				S_TRIM: begin
					if (trim_go_q) begin
						if (ptr_q == '0) begin
							trim_go_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q - CNT_W'(1);
						end
					end
					if ((valid_s1 && (rdata_q != tail_q)) || (!trim_go_q && !valid_s1)) begin
						if (count_q == CNT_W'(1) && tail_q == 16'd0) begin
							count_q <= '0;
						end
						state_q <= S_FIN;
					end else if (valid_s1) begin
						count_q <= CNT_W'(idx_s1) + CNT_W'(1);
					end
				end
				// search upward for an entry with no attribute bytes
				S_SCAN: begin
					if (rd_issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (valid_s1 && (rdata_q == scan_prev_q)) begin
						hit_idx_q <= CNT_W'(idx_s1);
						state_q   <= S_FIN;
					end else if (valid_s1) begin
						scan_prev_q <= rdata_q;
					end else if (!rd_issue) begin
						hit_idx_q <= count_q;
						if (count_q == CNT_W'(ENTRIES)) begin
							status_q <= ST_EMPTY;
						end
						state_q <= S_FIN;
					end
				end
				// load the result register once it is free
				S_FIN: begin
					if (out_free_w) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {free_fin_w, found_w, size_q, offset_q};
						m_tuser_q  <= status_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/iaot_checker.sv @@
// ----------------------------------------------------------------------------
// iaot_checker: port-level checks for the inode attribute offset table
// Watches the request and result streams of the top level; bound to it below.
// ----------------------------------------------------------------------------
module iaot_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [iaot_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic [iaot_pkg::OUT_USER_W-1:0]  m_tuser
);
	import iaot_pkg::*;

	// one request at a time: no transfer right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous one still in work");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// out of range reports no offset, size or found inode
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_RANGE) |-> (m_tdata[95:0] == 96'd0))
		else $error("out of range result carries data");

	// refused growth reports no found inode
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NOSPACE) |-> (m_tdata[95:32] == 64'd0))
		else $error("no space result carries a found inode");

endmodule

bind inode_attribute_offset_table_core iaot_checker u_iaot_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
